### rtl/pfc_pkg.sv
// Shared types, codes and helper functions for the Playfair cipher engine.
package pfc_pkg;

    // Square geometry and alphabet
    localparam int unsigned SIDE    = 5;
    localparam int unsigned CELLS   = SIDE * SIDE;
    localparam int unsigned LETTERS = 26;

    // Letter indexes with a special role
    localparam logic [4:0] IDX_I = 5'd8;
    localparam logic [4:0] IDX_J = 5'd9;
    localparam logic [4:0] IDX_X = 5'd23;
    localparam logic [4:0] IDX_LAST = 5'(LETTERS - 1);
    localparam logic [4:0] CELL_FULL = 5'(CELLS);

    // ASCII anchors
    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET   = 8'h20;

    // Input operation codes
    typedef enum logic [1:0] {
        OP_KEY_CHAR  = 2'd0,
        OP_KEY_END   = 2'd1,
        OP_TEXT_CHAR = 2'd2,
        OP_TEXT_END  = 2'd3
    } op_t;

    // Direction register values
    localparam logic DIR_ENCRYPT = 1'b0;
    localparam logic DIR_DECRYPT = 1'b1;

    // One write into both tables: square[cell_idx] = letter, position[letter] = cell_idx
    typedef struct packed {
        logic       we;
        logic [4:0] letter;
        logic [4:0] cell_idx;
    } tbl_wr_t;

    // Letter decode result
    typedef struct packed {
        logic       valid;
        logic [4:0] idx;
    } letter_t;

    // Fold case, keep letters only, J becomes I
    function automatic letter_t letter_index(input logic [7:0] c);
        logic [7:0] v;
        letter_t    r;
        v = c;
        if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z) begin
            v = c - CASE_OFFSET;
        end
        r.valid = (v >= ASCII_UPPER_A) && (v <= ASCII_UPPER_Z);
        r.idx   = 5'(v - ASCII_UPPER_A);
        if (r.idx == IDX_J) begin
            r.idx = IDX_I;
        end
        return r;
    endfunction

    // Row of a cell 0..24, by compare chain
    function automatic logic [2:0] pos_row(input logic [4:0] p);
        logic [2:0] r;
        if (p >= 5'd20)      r = 3'd4;
        else if (p >= 5'd15) r = 3'd3;
        else if (p >= 5'd10) r = 3'd2;
        else if (p >= 5'd5)  r = 3'd1;
        else                 r = 3'd0;
        return r;
    endfunction

    // Column of a cell 0..24
    function automatic logic [2:0] pos_col(input logic [4:0] p);
        logic [2:0] r;
        logic [4:0] base;
        r    = pos_row(p);
        base = {r, 2'b00} + {2'b00, r};
        return 3'(p - base);
    endfunction

    // Step one place along a row or column, wrapping at 5
    function automatic logic [2:0] step5(input logic [2:0] v, input logic dir);
        logic [2:0] r;
        if (dir == DIR_ENCRYPT) begin
            r = (v == 3'd4) ? 3'd0 : v + 3'd1;
        end else begin
            r = (v == 3'd0) ? 3'd4 : v - 3'd1;
        end
        return r;
    endfunction

    // Cell number from row and column
    function automatic logic [4:0] cell_of(input logic [2:0] r, input logic [2:0] c);
        return {r, 2'b00} + {2'b00, r} + {2'b00, c};
    endfunction

endpackage

### rtl/playfair_cipher_engine_core.sv
// Playfair cipher engine top level: sequencer, key state and result register.
//
//  channel | ports                                 | dir | meaning
//  --------+---------------------------------------+-----+---------------------------
//  s_      | s_valid s_ready s_operation s_char_in | in  | key/text characters, ends
//  m_      | m_valid m_ready m_out_letter m_last   | out | cipher letters, two a pair
//  cfg     | cfg_we cfg_wdata                      | in  | direction (0 enc, 1 dec)
//
// Key character, ignored character, or text character that only waits: taken in S_IDLE.
// Key end: one letter of the alphabet per cycle through the fill walk.
// Completed pair: position and square reads in S_RDA, S_RDB, S_SQX and S_SQY
// through the one read port of each table, S_OUT0 loads the first beat, then two
// result beats; s_ready is low until both are taken.
// Synchronous active-low reset clears the control state; the tables are not cleared.
module playfair_cipher_engine_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_operation,
    input  logic [7:0] s_char_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [6:0] m_out_letter,
    output logic       m_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_RDA,
        S_RDB,
        S_SQX,
        S_SQY,
        S_OUT0,
        S_OUT1
    } state_t;

    state_t      state_reg, state_next;
    logic        dir_reg, dir_next;
    logic [25:0] used_reg, used_next;
    logic [4:0]  fill_reg, fill_next;
    logic [4:0]  walk_reg, walk_next;
    logic [4:0]  pend_reg, pend_next;
    logic        pend_valid_reg, pend_valid_next;
    logic [4:0]  a_reg, a_next;
    logic [4:0]  b_reg, b_next;
    logic [4:0]  pa_reg, pa_next;
    logic [4:0]  pb_reg, pb_next;
    logic [4:0]  x_reg, x_next;
    logic [4:0]  y_reg, y_next;
    logic        m_valid_reg, m_valid_next;
    logic [6:0]  m_letter_reg, m_letter_next;
    logic        m_last_reg, m_last_next;

    pfc_pkg::tbl_wr_t wr;
    pfc_pkg::letter_t li;
    logic [4:0]  pos_raddr, pos_rdata, sq_raddr, sq_rdata;
    logic [4:0]  pb_cur;
    logic        accept;
    logic [4:0]  place_letter;

    assign s_ready      = (state_reg == S_IDLE);
    assign accept       = s_valid && s_ready;
    assign m_valid      = m_valid_reg;
    assign m_out_letter = m_letter_reg;
    assign m_last       = m_last_reg;
    assign li           = pfc_pkg::letter_index(s_char_in);

    // Table write: key character at accept, or one step of the fill walk
    assign place_letter = (state_reg == S_FILL) ? walk_reg : li.idx;
    always_comb begin
        wr.letter   = place_letter;
        wr.cell_idx = fill_reg;
        wr.we       = !used_reg[place_letter] && (fill_reg < pfc_pkg::CELL_FULL) &&
                      ((state_reg == S_FILL) ||
                       (accept && pfc_pkg::op_t'(s_operation) == pfc_pkg::OP_KEY_CHAR &&
                        li.valid));
    end

    // Read addresses
    assign pos_raddr = (state_reg == S_RDA) ? a_reg : b_reg;
    assign pb_cur    = (state_reg == S_SQX) ? pos_rdata : pb_reg;

    pfc_tables u_tables (
        .aclk      (aclk),
        .wr        (wr),
        .pos_raddr (pos_raddr),
        .pos_rdata (pos_rdata),
        .sq_raddr  (sq_raddr),
        .sq_rdata  (sq_rdata)
    );

    pfc_cell_unit u_cell (
        .pos_a    (pa_reg),
        .pos_b    (pb_cur),
        .dir      (dir_reg),
        .second   (state_reg == S_SQY),
        .cell_out (sq_raddr)
    );

    // Sequencer next state
    always_comb begin
        state_next      = state_reg;
        dir_next        = cfg_we ? cfg_wdata : dir_reg;
        used_next       = used_reg;
        fill_next       = fill_reg;
        walk_next       = walk_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        pa_next         = pa_reg;
        pb_next         = pb_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        m_valid_next    = m_valid_reg;
        m_letter_next   = m_letter_reg;
        m_last_next     = m_last_reg;

        // placement bookkeeping
        if (wr.we) begin
            used_next = used_reg | (26'd1 << wr.letter);
            fill_next = fill_reg + 5'd1;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (pfc_pkg::op_t'(s_operation))
                        pfc_pkg::OP_KEY_CHAR: begin
                        end
                        pfc_pkg::OP_KEY_END: begin
                            walk_next  = '0;
                            state_next = S_FILL;
                        end
                        pfc_pkg::OP_TEXT_CHAR: begin
                            if (li.valid) begin
                                if (!pend_valid_reg) begin
                                    pend_next       = li.idx;
                                    pend_valid_next = 1'b1;
                                end else begin
                                    a_next     = pend_reg;
                                    state_next = S_RDA;
                                    // double letter in encrypt: pair with X, keep pending
                                    if (dir_reg == pfc_pkg::DIR_ENCRYPT &&
                                        li.idx == pend_reg) begin
                                        b_next = pfc_pkg::IDX_X;
                                    end else begin
                                        b_next          = li.idx;
                                        pend_valid_next = 1'b0;
                                    end
                                end
                            end
                        end
                        pfc_pkg::OP_TEXT_END: begin
                            pend_valid_next = 1'b0;
                            if (pend_valid_reg && dir_reg == pfc_pkg::DIR_ENCRYPT) begin
                                a_next     = pend_reg;
                                b_next     = pfc_pkg::IDX_X;
                                state_next = S_RDA;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FILL: begin
                walk_next = walk_reg + 5'd1;
                if (walk_reg == pfc_pkg::IDX_LAST) begin
                    state_next = S_IDLE;
                end
            end
            S_RDA: begin
                state_next = S_RDB;
            end
            S_RDB: begin
                pa_next    = pos_rdata;
                state_next = S_SQX;
            end
            S_SQX: begin
                pb_next    = pos_rdata;
                state_next = S_SQY;
            end
            S_SQY: begin
                x_next     = sq_rdata;
                state_next = S_OUT0;
            end
            S_OUT0: begin
                // first beat goes out as soon as the second read lands
                if (!m_valid_reg) begin
                    y_next        = sq_rdata;
                    m_valid_next  = 1'b1;
                    m_letter_next = 7'(pfc_pkg::ASCII_UPPER_A) + {2'b00, x_reg};
                    m_last_next   = 1'b0;
                end else if (m_ready) begin
                    m_letter_next = 7'(pfc_pkg::ASCII_UPPER_A) + {2'b00, y_reg};
                    m_last_next   = 1'b1;
                    state_next    = S_OUT1;
                end
            end
            S_OUT1: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            dir_reg        <= pfc_pkg::DIR_ENCRYPT;
            used_reg       <= 26'd1 << pfc_pkg::IDX_J;
            fill_reg       <= '0;
            walk_reg       <= '0;
            pend_reg       <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            m_last_reg     <= 1'b0;
        end else begin
            state_reg      <= state_next;
            dir_reg        <= dir_next;
            used_reg       <= used_next;
            fill_reg       <= fill_next;
            walk_reg       <= walk_next;
            pend_reg       <= pend_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            m_last_reg     <= m_last_next;
        end
        a_reg        <= a_next;
        b_reg        <= b_next;
        pa_reg       <= pa_next;
        pb_reg       <= pb_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        m_letter_reg <= m_letter_next;
    end

    // No new item while a result beat is out
    a_busy_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken while result pending");

    // First beat of a pair is always followed by the second
    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=> (m_valid && m_last))
        else $error("pair broken after first beat");

    // Square never overfills
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= pfc_pkg::CELL_FULL)
        else $error("fill count beyond square");

    // J stays out of the square
    a_j_used: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg[pfc_pkg::IDX_J])
        else $error("J no longer marked used");

endmodule

### rtl/pfc_tables.sv
// Square and letter-position memories, one write and one registered read each.
module pfc_tables (
    input  logic            aclk,
    input  pfc_pkg::tbl_wr_t wr,
    input  logic [4:0]      pos_raddr,
    output logic [4:0]      pos_rdata,
    input  logic [4:0]      sq_raddr,
    output logic [4:0]      sq_rdata
);

    logic [4:0] square_mem [pfc_pkg::CELLS];
    logic [4:0] pos_mem    [pfc_pkg::LETTERS];

    // Both tables are written by the same placement
    always_ff @(posedge aclk) begin
        if (wr.we) begin
            square_mem[wr.cell_idx] <= wr.letter;
            pos_mem[wr.letter]      <= wr.cell_idx;
        end
    end

    // Registered reads
    always_ff @(posedge aclk) begin
        pos_rdata <= pos_mem[pos_raddr];
        sq_rdata  <= square_mem[sq_raddr];
    end

endmodule

### rtl/pfc_cell_unit.sv
// Shared pair rule unit: picks the output cell for either letter of a pair.
module pfc_cell_unit (
    input  logic [4:0] pos_a,
    input  logic [4:0] pos_b,
    input  logic       dir,
    input  logic       second,
    output logic [4:0] cell_out
);

    logic [2:0] r1, c1, r2, c2;
    logic [2:0] r_own, c_own, c_other;

    always_comb begin
        r1 = pfc_pkg::pos_row(pos_a);
        c1 = pfc_pkg::pos_col(pos_a);
        r2 = pfc_pkg::pos_row(pos_b);
        c2 = pfc_pkg::pos_col(pos_b);
        // own letter and partner letter for this half of the pair
        r_own   = second ? r2 : r1;
        c_own   = second ? c2 : c1;
        c_other = second ? c1 : c2;
        if (r1 == r2) begin
            cell_out = pfc_pkg::cell_of(r_own, pfc_pkg::step5(c_own, dir));
        end else if (c1 == c2) begin
            cell_out = pfc_pkg::cell_of(pfc_pkg::step5(r_own, dir), c_own);
        end else begin
            cell_out = pfc_pkg::cell_of(r_own, c_other);
        end
    end

endmodule
